### rtl/complex_arith_unit_macros.svh
// Assertion macros shared by the complex arithmetic unit RTL.
// No dependencies; included inside module bodies.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cau_pkg.sv
// Shared constants and types for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    localparam int CAU_DATA_WIDTH  = 32;
    localparam int CAU_FRAC_BITS   = 16;
    localparam int CAU_QUEUE_DEPTH = 4;
    localparam int CAU_QUEUE_AW    = 2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // one-hot operation class decided at the front
    typedef struct packed {
        logic is_add;
        logic is_sub;
        logic is_mul;
        logic is_div;
    } t_kind;

endpackage

### rtl/cau_front.sv
// Front end: accepts operand transactions, classifies the op code,
// and queues them for the back end. Depends on cau_pkg.
module cau_front #(
    parameter int DW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_op,
    input  logic [DW-1:0]   i_a_re,
    input  logic [DW-1:0]   i_a_im,
    input  logic [DW-1:0]   i_b_re,
    input  logic [DW-1:0]   i_b_im,
    output logic            o_valid,
    input  logic            i_pop,
    output cau_pkg::t_kind  o_kind,
    output logic [DW-1:0]   o_a_re,
    output logic [DW-1:0]   o_a_im,
    output logic [DW-1:0]   o_b_re,
    output logic [DW-1:0]   o_b_im
);
    import cau_pkg::*;

    localparam int EW = 4 + 4 * DW;

    logic [EW-1:0]           r_mem [0:CAU_QUEUE_DEPTH-1];
    logic [CAU_QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [CAU_QUEUE_AW:0]   r_cnt, n_cnt;
    t_kind                   n_kind;
    logic                    w_push, w_pop;
    logic [EW-1:0]           w_head;

    always_comb begin
        n_kind = '0;
        case (i_op)
            OP_ADD:  n_kind.is_add = 1'b1;
            OP_SUB:  n_kind.is_sub = 1'b1;
            OP_MUL:  n_kind.is_mul = 1'b1;
            OP_DIV:  n_kind.is_div = 1'b1;
            default: n_kind = '0;
        endcase
    end

    assign o_ready = (r_cnt != (CAU_QUEUE_AW+1)'(CAU_QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= {n_kind, i_b_im, i_b_re, i_a_im, i_a_re};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) r_wptr <= r_wptr + 1'b1;
            if (w_pop)  r_rptr <= r_rptr + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    assign w_head = r_mem[r_rptr];
    assign o_a_re = w_head[DW-1:0];
    assign o_a_im = w_head[2*DW-1:DW];
    assign o_b_re = w_head[3*DW-1:2*DW];
    assign o_b_im = w_head[4*DW-1:3*DW];
    assign o_kind = t_kind'(w_head[EW-1:4*DW]);

endmodule

### rtl/cau_divider.sv
// Pipelined restoring divider, one quotient bit per stage, two numerators
// sharing one denominator, with a sideband carried alongside. No dependencies.
module cau_divider #(
    parameter int DW  = 32,
    parameter int XW  = 113,
    parameter int SBW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [XW-1:0]     i_num_re,
    input  logic [XW-1:0]     i_num_im,
    input  logic [2*DW-1:0]   i_den,
    input  logic [SBW-1:0]    i_side,
    output logic              o_valid,
    output logic [DW-1:0]     o_q_re,
    output logic [DW-1:0]     o_q_im,
    output logic [SBW-1:0]    o_side
);

    logic [XW-1:0]   r_rem_re [0:DW-1];
    logic [XW-1:0]   r_rem_im [0:DW-1];
    logic [DW-1:0]   r_q_re   [0:DW-1];
    logic [DW-1:0]   r_q_im   [0:DW-1];
    logic [2*DW-1:0] r_den    [0:DW-1];
    logic [SBW-1:0]  r_side   [0:DW-1];
    logic [DW-1:0]   r_vld;

    logic [XW-1:0]   n_rem_re [0:DW-1];
    logic [XW-1:0]   n_rem_im [0:DW-1];
    logic [DW-1:0]   n_q_re   [0:DW-1];
    logic [DW-1:0]   n_q_im   [0:DW-1];
    logic [2*DW-1:0] n_den    [0:DW-1];
    logic [SBW-1:0]  n_side   [0:DW-1];

    // stage k decides quotient bit DW-1-k
    always_comb begin
        logic [XW-1:0]   s_re, s_im, s_dsh;
        logic [DW-1:0]   s_qre, s_qim;
        logic [2*DW-1:0] s_den;
        for (int k = 0; k < DW; k++) begin
            if (k == 0) begin
                s_re  = i_num_re;
                s_im  = i_num_im;
                s_qre = '0;
                s_qim = '0;
                s_den = i_den;
                n_side[k] = i_side;
            end else begin
                s_re  = r_rem_re[k-1];
                s_im  = r_rem_im[k-1];
                s_qre = r_q_re[k-1];
                s_qim = r_q_im[k-1];
                s_den = r_den[k-1];
                n_side[k] = r_side[k-1];
            end
            s_dsh = XW'(s_den) << (DW - 1 - k);
            n_den[k] = s_den;
            if (s_re >= s_dsh) begin
                n_rem_re[k] = s_re - s_dsh;
                n_q_re[k]   = {s_qre[DW-2:0], 1'b1};
            end else begin
                n_rem_re[k] = s_re;
                n_q_re[k]   = {s_qre[DW-2:0], 1'b0};
            end
            if (s_im >= s_dsh) begin
                n_rem_im[k] = s_im - s_dsh;
                n_q_im[k]   = {s_qim[DW-2:0], 1'b1};
            end else begin
                n_rem_im[k] = s_im;
                n_q_im[k]   = {s_qim[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_re <= n_rem_re;
            r_rem_im <= n_rem_im;
            r_q_re   <= n_q_re;
            r_q_im   <= n_q_im;
            r_den    <= n_den;
            r_side   <= n_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DW-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[DW-1];
    assign o_q_re  = r_q_re[DW-1];
    assign o_q_im  = r_q_im[DW-1];
    assign o_side  = r_side[DW-1];

endmodule

### rtl/cau_back.sv
// Back end: products, combine, divide pipeline, saturation and the
// output register. Depends on cau_pkg and cau_divider.
module cau_back #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_pop,
    input  cau_pkg::t_kind  i_kind,
    input  logic [DW-1:0]   i_a_re,
    input  logic [DW-1:0]   i_a_im,
    input  logic [DW-1:0]   i_b_re,
    input  logic [DW-1:0]   i_b_im,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [DW-1:0]   o_res_re,
    output logic [DW-1:0]   o_res_im,
    output logic            o_overflow,
    output logic            o_div_zero
);
    import cau_pkg::*;

    localparam int PW  = 2 * DW;
    localparam int MW  = PW + 1 + FB;
    localparam int XW  = MW + DW;
    localparam int SBW = 2 * DW + 7;
    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    logic w_adv;
    assign w_adv = !o_valid || i_ready;
    assign o_pop = w_adv;

    // stage 1: products and add/sub
    logic                 r1_vld;
    t_kind                r1_kind;
    logic signed [PW-1:0] r1_prr, r1_pii, r1_pir, r1_pri, r1_pbr, r1_pbi;
    logic [DW:0]          r1_sre, r1_sim;
    logic signed [PW-1:0] n1_prr, n1_pii, n1_pir, n1_pri, n1_pbr, n1_pbi;
    logic [DW:0]          n1_sre, n1_sim;

    assign n1_prr = $signed(i_a_re) * $signed(i_b_re);
    assign n1_pii = $signed(i_a_im) * $signed(i_b_im);
    assign n1_pir = $signed(i_a_im) * $signed(i_b_re);
    assign n1_pri = $signed(i_a_re) * $signed(i_b_im);
    assign n1_pbr = $signed(i_b_re) * $signed(i_b_re);
    assign n1_pbi = $signed(i_b_im) * $signed(i_b_im);
    assign n1_sre = i_kind.is_sub ? {i_a_re[DW-1], i_a_re} - {i_b_re[DW-1], i_b_re}
                                  : {i_a_re[DW-1], i_a_re} + {i_b_re[DW-1], i_b_re};
    assign n1_sim = i_kind.is_sub ? {i_a_im[DW-1], i_a_im} - {i_b_im[DW-1], i_b_im}
                                  : {i_a_im[DW-1], i_a_im} + {i_b_im[DW-1], i_b_im};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_kind <= i_kind;
            r1_prr  <= n1_prr;
            r1_pii  <= n1_pii;
            r1_pir  <= n1_pir;
            r1_pri  <= n1_pri;
            r1_pbr  <= n1_pbr;
            r1_pbi  <= n1_pbi;
            r1_sre  <= n1_sre;
            r1_sim  <= n1_sim;
        end
    end

    // stage 2: sums of products
    logic          r2_vld;
    t_kind         r2_kind;
    logic [PW:0]   r2_mre, r2_mim, r2_nre, r2_nim;
    logic [PW-1:0] r2_den;
    logic [DW:0]   r2_sre, r2_sim;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_kind <= r1_kind;
            r2_mre  <= {r1_prr[PW-1], r1_prr} - {r1_pii[PW-1], r1_pii};
            r2_mim  <= {r1_pir[PW-1], r1_pir} + {r1_pri[PW-1], r1_pri};
            r2_nre  <= {r1_prr[PW-1], r1_prr} + {r1_pii[PW-1], r1_pii};
            r2_nim  <= {r1_pir[PW-1], r1_pir} - {r1_pri[PW-1], r1_pri};
            r2_den  <= $unsigned(r1_pbr) + $unsigned(r1_pbi);
            r2_sre  <= r1_sre;
            r2_sim  <= r1_sim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
        end
    end

    // non-divide results finish here; divide operands get normalized to magnitudes
    logic signed [MW-1:0] w_mre_sh, w_mim_sh;
    logic [DW-1:0]        n_nd_re, n_nd_im;
    logic                 n_nd_ov;
    logic                 w_ov_re, w_ov_im;
    logic                 w_sg_re, w_sg_im, w_dz, w_pov_re, w_pov_im;
    logic [PW:0]          w_mag_re, w_mag_im;
    logic [XW-1:0]        w_num_re, w_num_im, w_den_hi;

    assign w_mre_sh = $signed({{FB{r2_mre[PW]}}, r2_mre}) >>> FB;
    assign w_mim_sh = $signed({{FB{r2_mim[PW]}}, r2_mim}) >>> FB;

    always_comb begin
        if (r2_kind.is_mul) begin
            w_ov_re = !(&w_mre_sh[MW-1:DW-1] || ~|w_mre_sh[MW-1:DW-1]);
            w_ov_im = !(&w_mim_sh[MW-1:DW-1] || ~|w_mim_sh[MW-1:DW-1]);
            n_nd_re = w_ov_re ? (w_mre_sh[MW-1] ? SMIN : SMAX) : w_mre_sh[DW-1:0];
            n_nd_im = w_ov_im ? (w_mim_sh[MW-1] ? SMIN : SMAX) : w_mim_sh[DW-1:0];
        end else begin
            w_ov_re = (r2_sre[DW] != r2_sre[DW-1]);
            w_ov_im = (r2_sim[DW] != r2_sim[DW-1]);
            n_nd_re = w_ov_re ? (r2_sre[DW] ? SMIN : SMAX) : r2_sre[DW-1:0];
            n_nd_im = w_ov_im ? (r2_sim[DW] ? SMIN : SMAX) : r2_sim[DW-1:0];
        end
        n_nd_ov = w_ov_re || w_ov_im;
    end

    assign w_sg_re  = r2_nre[PW];
    assign w_sg_im  = r2_nim[PW];
    assign w_mag_re = w_sg_re ? (~r2_nre + 1'b1) : r2_nre;
    assign w_mag_im = w_sg_im ? (~r2_nim + 1'b1) : r2_nim;
    assign w_num_re = XW'({w_mag_re, {FB{1'b0}}});
    assign w_num_im = XW'({w_mag_im, {FB{1'b0}}});
    assign w_den_hi = XW'({r2_den, {DW{1'b0}}});
    assign w_dz     = (r2_den == '0);
    // quotient of more than DW bits always saturates
    assign w_pov_re = (w_num_re >= w_den_hi);
    assign w_pov_im = (w_num_im >= w_den_hi);

    logic            d_vld;
    logic [DW-1:0]   d_qre, d_qim;
    logic [SBW-1:0]  d_side;

    cau_divider #(
        .DW  (DW),
        .XW  (XW),
        .SBW (SBW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (r2_vld),
        .i_num_re (w_num_re),
        .i_num_im (w_num_im),
        .i_den    (r2_den),
        .i_side   ({r2_kind.is_div, w_dz, w_pov_re, w_pov_im, w_sg_re, w_sg_im,
                    n_nd_ov, n_nd_im, n_nd_re}),
        .o_valid  (d_vld),
        .o_q_re   (d_qre),
        .o_q_im   (d_qim),
        .o_side   (d_side)
    );

    // output stage: divide saturation and result select
    logic          s_div, s_dz, s_pov_re, s_pov_im, s_sg_re, s_sg_im, s_nd_ov;
    logic [DW-1:0] s_nd_re, s_nd_im;
    logic          w_qov_re, w_qov_im;
    logic [DW-1:0] n_res_re, n_res_im;
    logic          n_ovf, n_dz;

    assign {s_div, s_dz, s_pov_re, s_pov_im, s_sg_re, s_sg_im,
            s_nd_ov, s_nd_im, s_nd_re} = d_side;

    assign w_qov_re = s_pov_re || (s_sg_re ? (d_qre[DW-1] && |d_qre[DW-2:0]) : d_qre[DW-1]);
    assign w_qov_im = s_pov_im || (s_sg_im ? (d_qim[DW-1] && |d_qim[DW-2:0]) : d_qim[DW-1]);

    always_comb begin
        if (!s_div) begin
            n_res_re = s_nd_re;
            n_res_im = s_nd_im;
            n_ovf    = s_nd_ov;
            n_dz     = 1'b0;
        end else if (s_dz) begin
            n_res_re = '0;
            n_res_im = '0;
            n_ovf    = 1'b0;
            n_dz     = 1'b1;
        end else begin
            n_res_re = w_qov_re ? (s_sg_re ? SMIN : SMAX) : (s_sg_re ? (~d_qre + 1'b1) : d_qre);
            n_res_im = w_qov_im ? (s_sg_im ? SMIN : SMAX) : (s_sg_im ? (~d_qim + 1'b1) : d_qim);
            n_ovf    = w_qov_re || w_qov_im;
            n_dz     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_res_re   <= n_res_re;
            o_res_im   <= n_res_im;
            o_overflow <= n_ovf;
            o_div_zero <= n_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= d_vld;
        end
    end

endmodule

### rtl/complex_arith_unit.sv
// Top level of the complex arithmetic unit (add, sub, mul, div on Q-format).
// Depends on cau_pkg, cau_front, cau_back and complex_arith_unit_macros.svh.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   i_s_tvalid/o_s_tready  tdata a_re,a_im,b_re,b_im; tuser op
// m_axis    out  o_m_tvalid/i_m_tready  tdata res_re,res_im; tuser overflow,div_zero
//
// Throughput: one transaction per cycle, for every op code, while the output is not stalled.
// Pipeline: from the queue head to the output register through the product stage,
//   sum stage, one divider stage per quotient bit and output stage.
// Stalls: the whole back pipeline holds while the output waits; a four-entry
//   queue behind the front keeps taking input until it fills.
// Reset: synchronous, active low, clears queue pointers, queue count and valid bits only.
module complex_arith_unit #(
    parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::CAU_FRAC_BITS,
    localparam int IN_W  = ((4 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // a_re, a_im, b_re, b_im (lowest first)
    input  logic [1:0]       i_s_tuser,   // op
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // res_re, res_im (lowest first)
    output logic [1:0]       o_m_tuser    // overflow, div_zero (lowest first)
);
    import cau_pkg::*;
    `include "complex_arith_unit_macros.svh"

    localparam int DW = DATA_WIDTH;
    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    // queue head toward the back end
    logic          q_valid, q_pop;
    t_kind         q_kind;
    logic [DW-1:0] q_a_re, q_a_im, q_b_re, q_b_im;

    logic [DW-1:0] res_re, res_im;
    logic          res_ovf, res_dz;

    cau_front #(
        .DW (DW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (i_s_tuser),
        .i_a_re  (i_s_tdata[DW-1:0]),
        .i_a_im  (i_s_tdata[2*DW-1:DW]),
        .i_b_re  (i_s_tdata[3*DW-1:2*DW]),
        .i_b_im  (i_s_tdata[4*DW-1:3*DW]),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_kind  (q_kind),
        .o_a_re  (q_a_re),
        .o_a_im  (q_a_im),
        .o_b_re  (q_b_re),
        .o_b_im  (q_b_im)
    );

    cau_back #(
        .DW (DW),
        .FB (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .o_pop      (q_pop),
        .i_kind     (q_kind),
        .i_a_re     (q_a_re),
        .i_a_im     (q_a_im),
        .i_b_re     (q_b_re),
        .i_b_im     (q_b_im),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_res_re   (res_re),
        .o_res_im   (res_im),
        .o_overflow (res_ovf),
        .o_div_zero (res_dz)
    );

    assign o_m_tdata = OUT_W'({res_im, res_re});
    assign o_m_tuser = {res_dz, res_ovf};

    // zero denominator never reports saturation
    `CAU_ASSERT_NOW(a_dz_no_ovf, i_clk, i_rst_n, o_m_tvalid && res_dz, !res_ovf, "div_zero with overflow")
    // zero denominator gives a zero result
    `CAU_ASSERT_NOW(a_dz_zero, i_clk, i_rst_n, o_m_tvalid && res_dz, res_re == '0 && res_im == '0, "div_zero result not zero")
    // a saturated result carries a clamp value in at least one part
    `CAU_ASSERT_NOW(a_ovf_clamp, i_clk, i_rst_n, o_m_tvalid && res_ovf, res_re == SMAX || res_re == SMIN || res_im == SMAX || res_im == SMIN, "overflow without clamp value")

endmodule
